>>> rtl/core/cew_pkg.sv
// shared constants and types for the color exchange window block
`default_nettype none

package cew_pkg;

    localparam int CEW_CHANNEL_BITS = 16;
    localparam int CEW_COLORS       = 3;
    localparam int CEW_CFG_IDX_BITS = 3;

    localparam int CEW_RED   = 0;
    localparam int CEW_GREEN = 1;
    localparam int CEW_BLUE  = 2;

    typedef enum logic [CEW_CFG_IDX_BITS-1:0] {
        CFG_SOURCE    = 3'd0,
        CFG_TARGET    = 3'd1,
        CFG_RED_TOL   = 3'd2,
        CFG_GREEN_TOL = 3'd3,
        CFG_BLUE_TOL  = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/core/cew_pix_in_if.sv
// input pixel stream channel
`default_nettype none

interface cew_pix_in_if #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] alpha_in;
    logic                    last_in;

    modport source (
        output valid, red_in, green_in, blue_in, alpha_in, last_in,
        input  ready
    );
    modport sink (
        input  valid, red_in, green_in, blue_in, alpha_in, last_in,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/cew_pix_out_if.sv
// output pixel stream channel
`default_nettype none

interface cew_pix_out_if #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic [CHANNEL_BITS-1:0] alpha_out;
    logic                    last_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, last_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, last_out,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/cew_cfg_if.sv
// configuration write channel
`default_nettype none

interface cew_cfg_if #(
    parameter int DATA_BITS = 3 * cew_pkg::CEW_CHANNEL_BITS
) ();
    logic                                  valid;
    logic                                  ready;
    logic [cew_pkg::CEW_CFG_IDX_BITS-1:0]  index;
    logic [DATA_BITS-1:0]                  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cew_cfg_regs.sv
// configuration register file
`default_nettype none

module cew_cfg_regs #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    cew_cfg_if.sink                                          i_cfg,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] o_source,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] o_target,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] o_tol
);
    localparam int COLOR_BITS = cew_pkg::CEW_COLORS * CHANNEL_BITS;

    logic [COLOR_BITS-1:0]                              r_source;
    logic [COLOR_BITS-1:0]                              r_target;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0]   r_tol;
    logic                                               wr_en;

    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= '1;
            r_target <= '0;
            r_tol    <= '0;
        end else if (wr_en) begin
            unique case (cew_pkg::t_cfg_idx'(i_cfg.index))
                cew_pkg::CFG_SOURCE:    r_source <= i_cfg.data[COLOR_BITS-1:0];
                cew_pkg::CFG_TARGET:    r_target <= i_cfg.data[COLOR_BITS-1:0];
                cew_pkg::CFG_RED_TOL: begin
                    r_tol[cew_pkg::CEW_RED] <= i_cfg.data[CHANNEL_BITS-1:0];
                end
                cew_pkg::CFG_GREEN_TOL: begin
                    r_tol[cew_pkg::CEW_GREEN] <= i_cfg.data[CHANNEL_BITS-1:0];
                end
                cew_pkg::CFG_BLUE_TOL: begin
                    r_tol[cew_pkg::CEW_BLUE] <= i_cfg.data[CHANNEL_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // red sits in the top slice of the packed color
    always_comb begin
        for (int c = 0; c < cew_pkg::CEW_COLORS; c++) begin
            o_source[c] = r_source[(cew_pkg::CEW_COLORS-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
            o_target[c] = r_target[(cew_pkg::CEW_COLORS-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
        end
    end
    assign o_tol = r_tol;

    a_red_tol_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && i_cfg.index == cew_pkg::CFG_RED_TOL)
        |=> r_tol[cew_pkg::CEW_RED] == $past(i_cfg.data[CHANNEL_BITS-1:0]))
        else $error("red tolerance write lost");

    a_unknown_index_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && i_cfg.index != cew_pkg::CFG_SOURCE && i_cfg.index != cew_pkg::CFG_TARGET
         && i_cfg.index != cew_pkg::CFG_RED_TOL && i_cfg.index != cew_pkg::CFG_GREEN_TOL
         && i_cfg.index != cew_pkg::CFG_BLUE_TOL)
        |=> ($stable(r_source) && $stable(r_target) && $stable(r_tol)))
        else $error("write to unknown index changed a register");

endmodule

`default_nettype wire

>>> rtl/core/cew_match.sv
// stage 1: window compares and color difference
`default_nettype none

module cew_match #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] i_px,
    input  logic [CHANNEL_BITS-1:0]                          i_alpha,
    input  logic                                             i_last,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] i_source,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] i_target,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] i_tol,
    output logic                                             o_valid,
    input  logic                                             i_ready,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] o_px,
    output logic [CHANNEL_BITS-1:0]                          o_alpha,
    output logic                                             o_last,
    output logic [cew_pkg::CEW_COLORS-1:0]                   o_in_win,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS:0]   o_delta
);
    logic                                             r_valid;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] r_px;
    logic [CHANNEL_BITS-1:0]                          r_alpha;
    logic                                             r_last;
    logic [cew_pkg::CEW_COLORS-1:0]                   r_in_win;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS:0]   r_delta;
    logic [cew_pkg::CEW_COLORS-1:0]                   n_in_win;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS:0]   n_delta;

    assign o_ready = !r_valid || i_ready;

    // px >= src - tol  <=>  px + tol >= src, and px <= src + tol;
    // clamping the bounds never changes either compare
    always_comb begin
        for (int c = 0; c < cew_pkg::CEW_COLORS; c++) begin
            n_in_win[c] = (({1'b0, i_px[c]} + {1'b0, i_tol[c]}) >= {1'b0, i_source[c]})
                       && ({1'b0, i_px[c]} <= ({1'b0, i_source[c]} + {1'b0, i_tol[c]}));
            n_delta[c]  = {1'b0, i_target[c]} - {1'b0, i_source[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_px     <= i_px;
            r_alpha  <= i_alpha;
            r_last   <= i_last;
            r_in_win <= n_in_win;
            r_delta  <= n_delta;
        end
    end

    assign o_valid  = r_valid;
    assign o_px     = r_px;
    assign o_alpha  = r_alpha;
    assign o_last   = r_last;
    assign o_in_win = r_in_win;
    assign o_delta  = r_delta;

endmodule

`default_nettype wire

>>> rtl/core/cew_sum.sv
// stage 2: match decision and shifted color
`default_nettype none

module cew_sum #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] i_px,
    input  logic [CHANNEL_BITS-1:0]                          i_alpha,
    input  logic                                             i_last,
    input  logic [cew_pkg::CEW_COLORS-1:0]                   i_in_win,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS:0]   i_delta,
    output logic                                             o_valid,
    input  logic                                             i_ready,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] o_px,
    output logic [CHANNEL_BITS-1:0]                          o_alpha,
    output logic                                             o_last,
    output logic                                             o_hit,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS+1:0] o_sum
);
    logic                                             r_valid;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] r_px;
    logic [CHANNEL_BITS-1:0]                          r_alpha;
    logic                                             r_last;
    logic                                             r_hit;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS+1:0] r_sum;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS+1:0] n_sum;

    assign o_ready = !r_valid || i_ready;

    // two's complement sum, two guard bits
    always_comb begin
        for (int c = 0; c < cew_pkg::CEW_COLORS; c++) begin
            n_sum[c] = {2'b00, i_px[c]} + {i_delta[c][CHANNEL_BITS], i_delta[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_px    <= i_px;
            r_alpha <= i_alpha;
            r_last  <= i_last;
            r_hit   <= &i_in_win;
            r_sum   <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_px    = r_px;
    assign o_alpha = r_alpha;
    assign o_last  = r_last;
    assign o_hit   = r_hit;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

>>> rtl/core/cew_sat.sv
// stage 3: saturation, select and output register
`default_nettype none

module cew_sat #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] i_px,
    input  logic [CHANNEL_BITS-1:0]                          i_alpha,
    input  logic                                             i_last,
    input  logic                                             i_hit,
    input  logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS+1:0] i_sum,
    output logic                                             o_valid,
    input  logic                                             i_ready,
    output logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] o_color,
    output logic [CHANNEL_BITS-1:0]                          o_alpha,
    output logic                                             o_last
);
    logic                                             r_valid;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] r_color;
    logic [CHANNEL_BITS-1:0]                          r_alpha;
    logic                                             r_last;
    logic [cew_pkg::CEW_COLORS-1:0][CHANNEL_BITS-1:0] n_color;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int c = 0; c < cew_pkg::CEW_COLORS; c++) begin
            priority if (!i_hit) begin
                n_color[c] = i_px[c];
            end else if (i_sum[c][CHANNEL_BITS+1]) begin
                n_color[c] = '0;
            end else if (i_sum[c][CHANNEL_BITS]) begin
                n_color[c] = '1;
            end else begin
                n_color[c] = i_sum[c][CHANNEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_color <= n_color;
            r_alpha <= i_alpha;
            r_last  <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_color = r_color;
    assign o_alpha = r_alpha;
    assign o_last  = r_last;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_valid && !i_ready))
        else $error("output stage blocked while empty");

endmodule

`default_nettype wire

>>> rtl/core/color_exchange_window_top.sv
// top level of the color exchange window block
`default_nettype none

// Color exchange with a per-channel match window. Each request on i_pix is
// one RGBA pixel; when red, green and blue all fall inside
// [source - tolerance, source + tolerance] (bounds clamped, both ends
// inclusive) the pixel is shifted by (target - source) per channel with
// saturation, otherwise it passes unchanged. Alpha and last always pass.
// Throughput is one pixel per clock while o_pix accepts. An accepted
// request passes a compare stage, an add stage and a saturate stage that
// is also the output register, on its way to o_pix. Every stage holds its
// data while the next one is full, so backpressure on o_pix ripples back
// through the three stage enables to i_pix.ready and no pixel is dropped
// or repeated. Configuration writes on i_cfg are always accepted and take
// effect on the next cycle; change them only while the pipeline is empty.
module color_exchange_window_top #(
    parameter int CHANNEL_BITS = cew_pkg::CEW_CHANNEL_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cew_pix_in_if.sink     i_pix,
    cew_pix_out_if.source  o_pix,
    cew_cfg_if.sink        i_cfg
);
    localparam int COLORS = cew_pkg::CEW_COLORS;

    // register file outputs, red at index 0
    logic [COLORS-1:0][CHANNEL_BITS-1:0] source;
    logic [COLORS-1:0][CHANNEL_BITS-1:0] target;
    logic [COLORS-1:0][CHANNEL_BITS-1:0] tol;

    // pixel entering the pipeline
    logic [COLORS-1:0][CHANNEL_BITS-1:0] in_px;

    // compare stage to add stage
    logic                                m_valid;
    logic                                m_ready;
    logic [COLORS-1:0][CHANNEL_BITS-1:0] m_px;
    logic [CHANNEL_BITS-1:0]             m_alpha;
    logic                                m_last;
    logic [COLORS-1:0]                   m_in_win;
    logic [COLORS-1:0][CHANNEL_BITS:0]   m_delta;

    // add stage to saturate stage
    logic                                s_valid;
    logic                                s_ready;
    logic [COLORS-1:0][CHANNEL_BITS-1:0] s_px;
    logic [CHANNEL_BITS-1:0]             s_alpha;
    logic                                s_last;
    logic                                s_hit;
    logic [COLORS-1:0][CHANNEL_BITS+1:0] s_sum;

    // result
    logic [COLORS-1:0][CHANNEL_BITS-1:0] out_color;

    // pixels in flight, for checking only
    logic [1:0] r_occ;
    logic [1:0] n_occ;
    logic       in_req;
    logic       out_req;

    cew_cfg_regs #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_source (source),
        .o_target (target),
        .o_tol    (tol)
    );

    assign in_px[cew_pkg::CEW_RED]   = i_pix.red_in;
    assign in_px[cew_pkg::CEW_GREEN] = i_pix.green_in;
    assign in_px[cew_pkg::CEW_BLUE]  = i_pix.blue_in;

    // stage 1: window test per channel, target minus source
    cew_match #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_px     (in_px),
        .i_alpha  (i_pix.alpha_in),
        .i_last   (i_pix.last_in),
        .i_source (source),
        .i_target (target),
        .i_tol    (tol),
        .o_valid  (m_valid),
        .i_ready  (m_ready),
        .o_px     (m_px),
        .o_alpha  (m_alpha),
        .o_last   (m_last),
        .o_in_win (m_in_win),
        .o_delta  (m_delta)
    );

    // stage 2: all-channel hit, pixel plus difference
    cew_sum #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (m_valid),
        .o_ready  (m_ready),
        .i_px     (m_px),
        .i_alpha  (m_alpha),
        .i_last   (m_last),
        .i_in_win (m_in_win),
        .i_delta  (m_delta),
        .o_valid  (s_valid),
        .i_ready  (s_ready),
        .o_px     (s_px),
        .o_alpha  (s_alpha),
        .o_last   (s_last),
        .o_hit    (s_hit),
        .o_sum    (s_sum)
    );

    // stage 3: clamp to the channel range, pick shifted or original color
    cew_sat #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_ready (s_ready),
        .i_px    (s_px),
        .i_alpha (s_alpha),
        .i_last  (s_last),
        .i_hit   (s_hit),
        .i_sum   (s_sum),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_color (out_color),
        .o_alpha (o_pix.alpha_out),
        .o_last  (o_pix.last_out)
    );

    assign o_pix.red_out   = out_color[cew_pkg::CEW_RED];
    assign o_pix.green_out = out_color[cew_pkg::CEW_GREEN];
    assign o_pix.blue_out  = out_color[cew_pkg::CEW_BLUE];

    // occupancy: requests taken minus results delivered, at most three
    assign in_req  = i_pix.valid && i_pix.ready;
    assign out_req = o_pix.valid && o_pix.ready;

    always_comb begin
        n_occ = r_occ;
        if (in_req && !out_req) begin
            n_occ = r_occ + 2'd1;
        end else if (!in_req && out_req) begin
            n_occ = r_occ - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    a_empty_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == 2'd0) |-> !o_pix.valid)
        else $error("result shown with no pixel in flight");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == 2'd3 && !o_pix.ready) |-> !i_pix.ready)
        else $error("request taken into a full pipeline");

    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != 2'd3) |-> i_pix.ready)
        else $error("input stalled while a stage is free");

endmodule

`default_nettype wire
